[rtl/core/pmvo_pkg.sv]
// Shared constants, codes and types for the Prim spanning-tree vertex order block.
// No dependencies; every file of the block imports this package.
package pmvo_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = VIDX_W + 1;
    localparam int W_W          = 10;
    localparam int MAT_AW       = 2 * VIDX_W;
    localparam int FUNC_W       = 2;

    localparam logic [W_W-1:0]   NO_EDGE    = W_W'(999);
    localparam logic [W_W-1:0]   MAX_WEIGHT = W_W'(998);

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EDGE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd2;

    // Control from the sequencer to the relaxation unit, one element per cycle.
    typedef struct packed {
        logic              issue;
        logic              start;
        logic              init;
        logic [VIDX_W-1:0] index;
    } pass_ctl_t;

endpackage

[rtl/core/pmvo_relax_unit.sv]
// Relaxation and minimum-search unit: holds the best-cost memory and folds
// each relaxed entry into the running minimum. Depends on pmvo_pkg.
module pmvo_relax_unit import pmvo_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pass_ctl_t               ctl,
    input  logic [W_W-1:0]          w_rd,
    input  logic [MAX_VERTICES-1:0] in_tree,
    output logic [VIDX_W-1:0]       pick,
    output logic [W_W-1:0]          lowest
);

    logic [W_W-1:0]    bc_mem [MAX_VERTICES];
    logic [W_W-1:0]    bc_rd_reg;
    logic              v1_reg;
    logic              init1_reg;
    logic [VIDX_W-1:0] j1_reg;
    logic [W_W-1:0]    low_reg, low_next;
    logic [VIDX_W-1:0] pick_reg, pick_next;
    logic [W_W-1:0]    new_bc;
    logic              outside;

    always_ff @(posedge aclk) begin
        if (ctl.issue) begin
            bc_rd_reg <= bc_mem[ctl.index];
        end
        if (v1_reg) begin
            bc_mem[j1_reg] <= new_bc;
        end
        j1_reg    <= ctl.index;
        init1_reg <= ctl.init;
    end

    always_comb begin
        outside = !in_tree[j1_reg];
        if (init1_reg) begin
            new_bc = w_rd;
        end else if (outside && (w_rd < bc_rd_reg)) begin
            new_bc = w_rd;
        end else begin
            new_bc = bc_rd_reg;
        end
        low_next  = low_reg;
        pick_next = pick_reg;
        if (ctl.start) begin
            low_next  = NO_EDGE;
            pick_next = '0;
        end else if (v1_reg && outside && (new_bc < low_reg)) begin
            low_next  = new_bc;
            pick_next = j1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            low_reg  <= NO_EDGE;
            pick_reg <= '0;
        end else begin
            v1_reg   <= ctl.issue;
            low_reg  <= low_next;
            pick_reg <= pick_next;
        end
    end

    assign pick   = pick_reg;
    assign lowest = low_reg;

    a_start_resets_min: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |=> (low_reg == NO_EDGE) && (pick_reg == '0))
        else $error("minimum not reset at pass start");

    a_min_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!ctl.start && !v1_reg) |=> $stable(pick_reg) && $stable(low_reg))
        else $error("minimum changed without a relaxed entry");

    a_relax_never_raises: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !init1_reg) |-> (new_bc <= bc_rd_reg))
        else $error("relaxation raised a best cost");

    a_min_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        low_reg <= NO_EDGE)
        else $error("running minimum above no-edge value");

endmodule

[rtl/core/prim_mst_vertex_order.sv]
// A run over n vertices takes n passes, each of n matrix reads, one drain step and one output
// step, plus any wait on m_tready.
// Results leave one per pass.
// An edge item also writes the mirrored entry; a clear item sweeps one matrix entry per cycle.
// Throughput is one item at a time; s_tready is low while an item is in progress.
// Reset (aresetn low, synchronous) starts the matrix clearing pass over all 4096 entries;
// configuration writes are taken at any time, items only after that pass.
module prim_mst_vertex_order import pmvo_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // edge_from[5:0], edge_to[11:6], edge_weight[21:12], zero
    input  logic [1:0]  s_tuser,    // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // vertex[5:0], zero
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EDGE  = 3'd2;
    localparam logic [2:0] S_PASS  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [MAT_AW-1:0]       clr_reg, clr_next;
    logic [VIDX_W-1:0]       j_reg, j_next;
    logic [VIDX_W-1:0]       step_reg, step_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic                    init_reg, init_next;
    logic [VIDX_W-1:0]       row_reg, row_next;
    logic [MAX_VERTICES-1:0] in_tree_reg, in_tree_next;
    logic [CNT_W-1:0]        vcount_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [VIDX_W-1:0]       m_vertex_reg, m_vertex_next;
    logic                    m_last_reg, m_last_next;
    logic [VIDX_W-1:0]       edge_a_reg, edge_b_reg;
    logic [W_W-1:0]          edge_w_reg;

    logic [W_W-1:0]          wmat [MAX_VERTICES*MAX_VERTICES];
    logic [W_W-1:0]          w_rd_reg;
    logic                    wr_en;
    logic [MAT_AW-1:0]       wr_addr;
    logic [W_W-1:0]          wr_data;
    logic                    rd_en;

    logic                    s_accept;
    logic [VIDX_W-1:0]       in_from, in_to;
    logic [W_W-1:0]          in_weight, in_weight_sat;
    logic [CNT_W-1:0]        n_clamped;
    logic                    out_free;
    logic                    step_last;
    pass_ctl_t               ctl;
    logic [VIDX_W-1:0]       pick;
    logic [W_W-1:0]          lowest;

    assign in_from       = s_tdata[VIDX_W-1:0];
    assign in_to         = s_tdata[2*VIDX_W-1:VIDX_W];
    assign in_weight     = s_tdata[2*VIDX_W+W_W-1:2*VIDX_W];
    assign in_weight_sat = (in_weight > MAX_WEIGHT) ? NO_EDGE : in_weight;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8-VIDX_W){1'b0}}, m_vertex_reg};
    assign m_tlast  = m_last_reg;

    always_comb begin
        if (vcount_reg == '0) begin
            n_clamped = CNT_W'(1);
        end else if (vcount_reg > CNT_W'(MAX_VERTICES)) begin
            n_clamped = CNT_W'(MAX_VERTICES);
        end else begin
            n_clamped = vcount_reg;
        end
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign step_last = ({1'b0, step_reg} == (n_reg - CNT_W'(1)));

    // Matrix write port: clearing sweep, first half of an edge write, mirrored half.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = (clr_reg[MAT_AW-1:VIDX_W] == clr_reg[VIDX_W-1:0]) ? '0 : NO_EDGE;
        unique case (state_reg)
            S_CLR: begin
                wr_en = 1'b1;
            end
            S_IDLE: begin
                if (s_accept && (s_tuser == FUNC_EDGE)) begin
                    wr_en   = 1'b1;
                    wr_addr = {in_from, in_to};
                    wr_data = in_weight_sat;
                end
            end
            S_EDGE: begin
                wr_en   = 1'b1;
                wr_addr = {edge_b_reg, edge_a_reg};
                wr_data = edge_w_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign rd_en = (state_reg == S_PASS);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            wmat[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            w_rd_reg <= wmat[{row_reg, j_reg}];
        end
        if (s_accept) begin
            edge_a_reg <= in_from;
            edge_b_reg <= in_to;
            edge_w_reg <= in_weight_sat;
        end
    end

    always_comb begin
        ctl.issue = (state_reg == S_PASS);
        ctl.start = (state_reg == S_PASS) && (j_reg == '0);
        ctl.init  = init_reg;
        ctl.index = j_reg;
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        j_next        = j_reg;
        step_next     = step_reg;
        n_next        = n_reg;
        init_next     = init_reg;
        row_next      = row_reg;
        in_tree_next  = in_tree_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_vertex_next = m_vertex_reg;
        m_last_next   = m_last_reg;
        unique case (state_reg)
            S_CLR: begin
                clr_next = clr_reg + MAT_AW'(1);
                if (clr_reg == {MAT_AW{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    unique case (s_tuser)
                        FUNC_CLEAR: begin
                            clr_next   = '0;
                            state_next = S_CLR;
                        end
                        FUNC_EDGE: begin
                            state_next = S_EDGE;
                        end
                        FUNC_RUN: begin
                            n_next       = n_clamped;
                            in_tree_next = '0;
                            init_next    = 1'b1;
                            row_next     = '0;
                            j_next       = '0;
                            step_next    = '0;
                            state_next   = S_PASS;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EDGE: begin
                state_next = S_IDLE;
            end
            S_PASS: begin
                if ({1'b0, j_reg} == (n_reg - CNT_W'(1))) begin
                    state_next = S_DRAIN;
                end else begin
                    j_next = j_reg + VIDX_W'(1);
                end
            end
            S_DRAIN: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                // The picked vertex joins the tree and its row drives the next pass.
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_vertex_next      = pick;
                    m_last_next        = step_last;
                    in_tree_next[pick] = 1'b1;
                    row_next           = pick;
                    init_next          = 1'b0;
                    j_next             = '0;
                    step_next          = step_reg + VIDX_W'(1);
                    state_next         = step_last ? S_IDLE : S_PASS;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            j_reg        <= '0;
            step_reg     <= '0;
            n_reg        <= CNT_W'(MAX_VERTICES);
            init_reg     <= 1'b0;
            row_reg      <= '0;
            in_tree_reg  <= '0;
            vcount_reg   <= CNT_W'(MAX_VERTICES);
            m_valid_reg  <= 1'b0;
            m_vertex_reg <= '0;
            m_last_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            j_reg        <= j_next;
            step_reg     <= step_next;
            n_reg        <= n_next;
            init_reg     <= init_next;
            row_reg      <= row_next;
            in_tree_reg  <= in_tree_next;
            m_valid_reg  <= m_valid_next;
            m_vertex_reg <= m_vertex_next;
            m_last_reg   <= m_last_next;
            if (cfg_valid && cfg_ready) begin
                vcount_reg <= cfg_data;
            end
        end
    end

    pmvo_relax_unit u_relax (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .w_rd    (w_rd_reg),
        .in_tree (in_tree_reg),
        .pick    (pick),
        .lowest  (lowest)
    );

    a_out_only_from_sequencer: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && !(state_reg == S_OUT)) |=> !m_valid_reg)
        else $error("result transfer raised outside the output step");

    a_found_vertex_outside_tree: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && lowest != NO_EDGE) |-> !in_tree_reg[pick])
        else $error("picked vertex already in the tree");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PASS || state_reg == S_CLR) |-> !s_tready)
        else $error("input ready while a run or clear is in progress");

endmodule
